@@ hdl/bus_master_range_match_table_unit_macros.svh @@
// Assertion macros for the bus-master range match table.
`ifndef BUS_MASTER_RANGE_MATCH_TABLE_UNIT_MACROS_SVH
`define BUS_MASTER_RANGE_MATCH_TABLE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked check, muted while reset is asserted
`define BMRM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Clocked check that also holds during reset
`define BMRM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define BMRM_ASSERT(label, prop, msg)
`define BMRM_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ hdl/bmrm_pkg.sv @@
// Shared constants and types for the bus-master range match table.
package bmrm_pkg;

  // Default table capacity
  localparam int unsigned TABLE_DEPTH_DEF = 32;

  // Field widths
  localparam int unsigned ID_W     = 8;
  localparam int unsigned MASK_W   = 16;
  localparam int unsigned MOD_W    = 32;
  localparam int unsigned BUS_W    = 4;
  localparam int unsigned LIMIT_W  = 5;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPORTED_MASK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUS_LIMIT      = 1'd1;

  // Configuration reset values
  localparam logic [MASK_W-1:0]  SUPPORTED_MASK_RST = 16'hFFFF;
  localparam logic [LIMIT_W-1:0] BUS_LIMIT_RST      = 5'd16;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_REGISTERED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REVERSED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERLAP     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_HIT         = 3'd5;
  localparam logic [STATUS_W-1:0] ST_MISS        = 3'd6;
  localparam logic [STATUS_W-1:0] ST_BAD_BUS     = 3'd7;

  // Actions
  localparam logic ACT_REGISTER = 1'b0;
  localparam logic ACT_LOOKUP   = 1'b1;

  // One stored table entry
  typedef struct packed {
    logic [ID_W-1:0]   first;
    logic [ID_W-1:0]   last;
    logic [MASK_W-1:0] buses;
    logic [MOD_W-1:0]  module_id;
  } entry_t;

endpackage

@@ hdl/bus_master_range_match_table_unit.sv @@
// Bus-master range match table: register and look up master ID ranges per bus.
// Results: a rejected register (full, reversed, unsupported) or a bad bus index returns
//   its result in the cycle after start; a scan reads every stored entry, then registers its result.
// Throughput: busy covers the scan, one entry per cycle, and the next request is taken in the
//   result cycle; a rejected request leaves busy low, so rejects can follow every cycle.
// The result strobe done_o is high for one cycle; the receiver cannot stall it.
`include "bus_master_range_match_table_unit_macros.svh"

module bus_master_range_match_table_unit
  import bmrm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Command channel
  input  logic                  start,
  output logic                  busy,
  input  logic                  action_i,
  input  logic [ID_W-1:0]       range_start_i,
  input  logic [ID_W-1:0]       range_end_i,
  input  logic [MASK_W-1:0]     bus_mask_i,
  input  logic [MOD_W-1:0]      module_id_i,
  input  logic [BUS_W-1:0]      bus_index_i,
  input  logic [ID_W-1:0]       master_id_i,
  // Result
  output logic                  done_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic                  found_o,
  output logic [MOD_W-1:0]      found_module_o,
  // Configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Sequencer codes
  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_SCAN = 1'b1;

  logic [0:0]          state_q, state_d;
  logic [CW-1:0]       count_q;
  logic [CW-1:0]       idx_q;
  logic                rd_vld_q;
  entry_t              rd_q;
  entry_t              mem_q [TABLE_DEPTH];

  // Latched request
  logic                act_q;
  logic [ID_W-1:0]     lo_q, hi_q, mid_q;
  logic [MASK_W-1:0]   mask_q;
  logic [MOD_W-1:0]    mod_q;
  logic [MASK_W-1:0]   bit_q;

  // Scan accumulators
  logic                clash_q, hit_q;
  logic [MOD_W-1:0]    hit_mod_q;

  // Configuration
  logic [MASK_W-1:0]   sup_mask_q;
  logic [LIMIT_W-1:0]  bus_limit_q;

  // Result registers
  logic                done_q;
  logic [STATUS_W-1:0] status_q;
  logic                found_q;
  logic [MOD_W-1:0]    found_mod_q;

  logic                accept;
  logic                early_fail;
  logic [STATUS_W-1:0] early_status;
  logic                issue;
  logic                scan_end;
  logic                rd_clash, rd_match;
  logic                do_write;

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // Checks that need no table access
  always_comb begin
    early_fail   = 1'b0;
    early_status = ST_REGISTERED;
    if (action_i == ACT_REGISTER) begin
      if (count_q == CW'(TABLE_DEPTH)) begin
        early_fail   = 1'b1;
        early_status = ST_FULL;
      end else if (range_start_i > range_end_i) begin
        early_fail   = 1'b1;
        early_status = ST_REVERSED;
      end else if ((bus_mask_i & sup_mask_q) == '0) begin
        early_fail   = 1'b1;
        early_status = ST_UNSUPPORTED;
      end
    end else if ({1'b0, bus_index_i} >= bus_limit_q) begin
      early_fail   = 1'b1;
      early_status = ST_BAD_BUS;
    end
  end

  // Compare unit on the entry read last cycle
  assign rd_clash = (hi_q >= rd_q.first) && (lo_q <= rd_q.last) && ((mask_q & rd_q.buses) != '0);
  assign rd_match = ((bit_q & rd_q.buses) != '0) && (mid_q >= rd_q.first) &&
                    (mid_q <= rd_q.last);

  assign issue    = (state_q == S_SCAN) && (idx_q < count_q);
  assign scan_end = (state_q == S_SCAN) && !issue && !rd_vld_q;
  assign do_write = scan_end && (act_q == ACT_REGISTER) && !clash_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept && !early_fail) state_d = S_SCAN;
      S_SCAN: if (scan_end) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      done_q      <= 1'b0;
      clash_q     <= 1'b0;
      hit_q       <= 1'b0;
      sup_mask_q  <= SUPPORTED_MASK_RST;
      bus_limit_q <= BUS_LIMIT_RST;
    end else begin
      state_q  <= state_d;
      done_q   <= (accept && early_fail) || scan_end;
      rd_vld_q <= issue;
      if (accept) begin
        idx_q   <= '0;
        clash_q <= 1'b0;
        hit_q   <= 1'b0;
      end else begin
        if (issue) idx_q <= idx_q + 1'b1;
        if (rd_vld_q && rd_clash) clash_q <= 1'b1;
        if (rd_vld_q && rd_match) hit_q <= 1'b1;
      end
      if (do_write) count_q <= count_q + 1'b1;
      // Configuration writes
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_SUPPORTED_MASK: sup_mask_q  <= cfg_data_i;
          CFG_BUS_LIMIT:      bus_limit_q <= cfg_data_i[LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= action_i;
      lo_q   <= range_start_i;
      hi_q   <= range_end_i;
      mask_q <= bus_mask_i;
      mod_q  <= module_id_i;
      mid_q  <= master_id_i;
      bit_q  <= MASK_W'(1) << bus_index_i;
    end
    if (!accept && rd_vld_q && rd_match) hit_mod_q <= rd_q.module_id;
    // Result
    if (accept && early_fail) begin
      status_q    <= early_status;
      found_q     <= 1'b0;
      found_mod_q <= '0;
    end else if (scan_end) begin
      if (act_q == ACT_REGISTER) begin
        status_q    <= clash_q ? ST_OVERLAP : ST_REGISTERED;
        found_q     <= 1'b0;
        found_mod_q <= '0;
      end else begin
        status_q    <= hit_q ? ST_HIT : ST_MISS;
        found_q     <= hit_q;
        found_mod_q <= hit_q ? hit_mod_q : '0;
      end
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (do_write) mem_q[count_q[IW-1:0]] <= '{first: lo_q, last: hi_q, buses: mask_q,
                                               module_id: mod_q};
    if (issue) rd_q <= mem_q[idx_q[IW-1:0]];
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign found_o        = found_q;
  assign found_module_o = found_mod_q;

  // Assertions
  `BMRM_ASSERT_ALWAYS(a_count_bound, !rst_ni || (count_q <= CW'(TABLE_DEPTH)), "entry count above depth")
  `BMRM_ASSERT(a_done_idle, done_q |-> (state_q == S_IDLE), "result strobe while scanning")
  `BMRM_ASSERT(a_read_in_scan, rd_vld_q |-> (state_q == S_SCAN), "table read outside scan")
  `BMRM_ASSERT(a_found_hit, (done_o && found_o) |-> (status_o == ST_HIT), "found without hit status")
  `BMRM_ASSERT(a_count_grow, (count_q != $past(count_q)) |-> (done_q && (status_o == ST_REGISTERED)), "entry count moved without a registration")

endmodule
